>>> hw/rtl/skc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skc_pkg: shared constants and types for spatial_kernel_correlation
// Fixed-point constants, kernel codes and the 2^(-i/16) lookup table.
// ----------------------------------------------------------------------------
package skc_pkg;

  typedef enum logic [1:0] {
    KERN_EXP   = 2'd0,
    KERN_M32   = 2'd1,
    KERN_M52   = 2'd2,
    KERN_SQEXP = 2'd3
  } kernel_e;

  localparam logic [0:0] REG_INV_LS = 1'b0;
  localparam logic [0:0] REG_KSEL   = 1'b1;

  localparam int unsigned CFG_WIDTH = 24;
  localparam int unsigned DIST_W    = 17;
  localparam int unsigned CORR_W    = 17;
  localparam int unsigned X_W       = 23;   // x clamped to 1<<22

  localparam logic [16:0] SQRT3_Q16 = 17'd113512;
  localparam logic [17:0] SQRT5_Q16 = 18'd146543;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [16:0] Q16_ONE   = 17'd65536;
  localparam logic [16:0] DIST_MAX  = 17'd131071;
  localparam logic [22:0] X_CLAMP   = 23'd4194304;
  localparam logic [17:0] DIFF_CLAMP = 18'd131072;

  function automatic logic [16:0] pow2_neg(input logic [4:0] idx);
    logic [16:0] r;
    begin
      case (idx)
        5'd0:  r = 17'd65536;
        5'd1:  r = 17'd62757;
        5'd2:  r = 17'd60097;
        5'd3:  r = 17'd57549;
        5'd4:  r = 17'd55109;
        5'd5:  r = 17'd52773;
        5'd6:  r = 17'd50535;
        5'd7:  r = 17'd48393;
        5'd8:  r = 17'd46341;
        5'd9:  r = 17'd44376;
        5'd10: r = 17'd42495;
        5'd11: r = 17'd40693;
        5'd12: r = 17'd38968;
        5'd13: r = 17'd37316;
        5'd14: r = 17'd35734;
        5'd15: r = 17'd34219;
        5'd16: r = 17'd32768;
        default: r = 17'd0;
      endcase
      return r;
    end
  endfunction

endpackage

>>> hw/rtl/skc_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skc_isqrt: pipelined integer square root
// Restoring square root, BPS result bits per register stage.
// Carries a side payload alongside; advances when en_i is high.
// ----------------------------------------------------------------------------
module skc_isqrt #(
  parameter int unsigned IN_W   = 38,
  parameter int unsigned SIDE_W = 1,
  parameter int unsigned BPS    = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [IN_W-1:0]         rad_i,
  input  logic [SIDE_W-1:0]       side_i,
  output logic                    valid_o,
  output logic [(IN_W+1)/2-1:0]   root_o,
  output logic [SIDE_W-1:0]       side_o
);

  localparam int unsigned RW     = (IN_W + 1) / 2;
  localparam int unsigned PW     = 2 * RW;
  localparam int unsigned STAGES = (RW + BPS - 1) / BPS;
  localparam int unsigned RMW    = RW + 2;

  logic [PW-1:0]     rad_q  [STAGES+1];
  logic [RMW-1:0]    rem_q  [STAGES+1];
  logic [RW-1:0]     root_q [STAGES+1];
  logic [SIDE_W-1:0] side_q [STAGES+1];
  logic              vld_q  [STAGES+1];

  assign rad_q[0]  = PW'(rad_i);
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign side_q[0] = side_i;
  assign vld_q[0]  = valid_i;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [PW-1:0]  rad_d;
    logic [RMW-1:0] rem_d;
    logic [RW-1:0]  root_d;

    always_comb begin
      logic [RMW-1:0] trial;
      trial  = '0;
      rad_d  = rad_q[s];
      rem_d  = rem_q[s];
      root_d = root_q[s];
      for (int b = 0; b < BPS; b++) begin
        if ((s * BPS + b) < RW) begin
          rem_d  = {rem_d[RMW-3:0], rad_d[PW-1 -: 2]};
          rad_d  = {rad_d[PW-3:0], 2'b00};
          trial  = {root_d, 2'b01};
          if (rem_d >= trial) begin
            rem_d  = rem_d - trial;
            root_d = {root_d[RW-2:0], 1'b1};
          end else begin
            root_d = {root_d[RW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[s+1]  <= rad_d;
        rem_q[s+1]  <= rem_d;
        root_q[s+1] <= root_d;
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign valid_o = vld_q[STAGES];
  assign root_o  = root_q[STAGES];
  assign side_o  = side_q[STAGES];

endmodule

>>> hw/rtl/spatial_kernel_correlation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spatial_kernel_correlation: Matern-family covariance kernel
// Distance between two points and one of four correlation kernels.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one point pair per transaction: tdata holds point A
//   coordinates 0..3 then point B coordinates 0..3 (signed Q8.8).
//   m_axis returns one transaction per input: distance (Q9.8) in the low
//   17 bits and correlation (Q1.16) above it.
//   Configuration: cfg_we_i writes inv_length_scale (index 0) or
//   kernel_select (index 1); write only while idle.
// Throughput: one transaction per cycle while m_axis does not stall; the
//   whole datapath is a single pipeline with a common enable.
// Depth: 3 + ceil(19/4) + 10 = 18 register stages with default
//   parameters, set by the square-root stages and the exp/multiply stages.
// Stall: when m_axis_tready is low and the output register is full the
//   whole pipeline freezes; s_axis_tready drops and nothing is lost.
// Reset: clears all valid bits and loads inv_length_scale = 1.0 and the
//   squared-exponential kernel.
// ----------------------------------------------------------------------------
module spatial_kernel_correlation #(
  parameter int unsigned DIMS        = 4,
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // a_c0, a_c1, a_c2, a_c3, b_c0, b_c1, b_c2, b_c3 (each COORD_WIDTH)
  input  logic [((8*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // distance[16:0], correlation[33:17], zero fill
  output logic [39:0]                      m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic [0:0]                       cfg_index_i,
  input  logic [skc_pkg::CFG_WIDTH-1:0]    cfg_data_i
);

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned SQW  = 35;               // (2^17)^2 = 2^34
  localparam int unsigned SUMW = SQW + 2;          // four terms
  localparam int unsigned RADW = SUMW + 1;         // even width for isqrt
  localparam int unsigned RTW  = RADW / 2;

  // ---------------- configuration ----------------
  logic [23:0] inv_ls_q;
  logic [1:0]  ksel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_ls_q <= 24'd65536;
      ksel_q   <= 2'(skc_pkg::KERN_SQEXP);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        skc_pkg::REG_INV_LS: inv_ls_q <= cfg_data_i;
        skc_pkg::REG_KSEL:   ksel_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline enable ----------------
  logic en;
  logic out_vld_q;
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // ---------------- stage 1: abs differences ----------------
  logic        v1_q;
  logic [17:0] ad_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= s_axis_tvalid;
  end

  for (genvar h = 0; h < 4; h++) begin : g_diff
    logic signed [CW:0] a, b, d;
    logic [CW:0]        mag;
    logic [17:0]        adc;
    always_comb begin
      a   = (CW+1)'($signed(s_axis_tdata[h*CW +: CW]));
      b   = (CW+1)'($signed(s_axis_tdata[(4+h)*CW +: CW]));
      d   = a - b;
      mag = d[CW] ? (CW+1)'(-d) : (CW+1)'(d);
      if (h >= DIMS) adc = '0;
      else if (33'(mag) > 33'(skc_pkg::DIFF_CLAMP)) adc = skc_pkg::DIFF_CLAMP;
      else adc = 18'(mag);
    end
    always_ff @(posedge clk_i) begin
      if (en) ad_q[h] <= adc;
    end
  end

  // ---------------- stage 2: squares ----------------
  logic           v2_q;
  logic [SQW-1:0] sq_q [4];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end
  for (genvar h = 0; h < 4; h++) begin : g_sq
    always_ff @(posedge clk_i) begin
      if (en) sq_q[h] <= SQW'(ad_q[h] * ad_q[h]);
    end
  end

  // ---------------- stage 3: sum ----------------
  logic            v3_q;
  logic [SUMW-1:0] sum_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) sum_q <= SUMW'(sq_q[0]) + SUMW'(sq_q[1]) + SUMW'(sq_q[2]) + SUMW'(sq_q[3]);
  end

  // ---------------- square root ----------------
  logic           vr;
  logic [RTW-1:0] root;
  logic [1:0]     ksel_r;

  skc_isqrt #(.IN_W(RADW), .SIDE_W(2), .BPS(4)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .rad_i   (RADW'(sum_q)),
    .side_i  (ksel_q),
    .valid_o (vr),
    .root_o  (root),
    .side_o  (ksel_r)
  );

  // ---------------- stage A: saturate distance, scale ----------------
  logic        va_q;
  logic [16:0] dist_a_q;
  logic [40:0] xp_a_q;
  logic [1:0]  ks_a_q;
  logic [16:0] dsat;
  assign dsat = (RTW'(skc_pkg::DIST_MAX) < root) ? skc_pkg::DIST_MAX : 17'(root);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else if (en) va_q <= vr;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_a_q <= dsat;
      xp_a_q   <= 41'(dsat * inv_ls_q);
      ks_a_q   <= ksel_r;
    end
  end

  // ---------------- stage B: clamp x, kernel argument product ----------------
  logic [22:0] x_b;
  assign x_b = (xp_a_q[40:8] > 33'(skc_pkg::X_CLAMP)) ? skc_pkg::X_CLAMP : xp_a_q[30:8];

  logic        vb_q;
  logic [16:0] dist_b_q;
  logic [1:0]  ks_b_q;
  logic [45:0] zp_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else if (en) vb_q <= va_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_b_q <= dist_a_q;
      ks_b_q   <= ks_a_q;
      case (ks_a_q)
        2'(skc_pkg::KERN_EXP):   zp_b_q <= 46'({x_b, 16'd0});
        2'(skc_pkg::KERN_M32):   zp_b_q <= 46'(x_b * skc_pkg::SQRT3_Q16);
        2'(skc_pkg::KERN_M52):   zp_b_q <= 46'(x_b * skc_pkg::SQRT5_Q16);
        default:                 zp_b_q <= ({23'd0, x_b} * {23'd0, x_b}) >> 1;
      endcase
    end
  end

  // z = zp >> 16; squared exp holds x*x >> 1, so the same shift gives x*x >> 17
  logic [29:0] z_c;
  assign z_c = 30'(zp_b_q >> 16);

  // ---------------- stage C: z, log2 product ----------------
  logic        vc_q;
  logic [16:0] dist_c_q;
  logic [1:0]  ks_c_q;
  logic [29:0] z_c_q;
  logic [46:0] t_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else if (en) vc_q <= vb_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_c_q <= dist_b_q;
      ks_c_q   <= ks_b_q;
      z_c_q    <= z_c;
      t_c_q    <= 47'(z_c * skc_pkg::LOG2E_Q16);
    end
  end

  // ---------------- stage D: table lookup ----------------
  logic [30:0] t_d;
  assign t_d = t_c_q[46:16];

  logic        vd_q;
  logic [16:0] dist_d_q;
  logic [1:0]  ks_d_q;
  logic [29:0] z_d_q;
  logic [16:0] t0_d_q, dt_d_q;
  logic [11:0] lo_d_q;
  logic [4:0]  k_d_q;
  logic        kbig_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vd_q <= 1'b0;
    else if (en) vd_q <= vc_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_d_q <= dist_c_q;
      ks_d_q   <= ks_c_q;
      z_d_q    <= z_c_q;
      t0_d_q   <= skc_pkg::pow2_neg({1'b0, t_d[15:12]});
      dt_d_q   <= skc_pkg::pow2_neg({1'b0, t_d[15:12]})
                - skc_pkg::pow2_neg(5'({1'b0, t_d[15:12]} + 5'd1));
      lo_d_q   <= t_d[11:0];
      kbig_d_q <= (t_d[30:16] >= 15'd17);
      k_d_q    <= t_d[20:16];
    end
  end

  // ---------------- stage E: interpolation product ----------------
  logic        ve_q;
  logic [16:0] dist_e_q;
  logic [1:0]  ks_e_q;
  logic [29:0] z_e_q;
  logic [16:0] t0_e_q;
  logic [28:0] ip_e_q;
  logic [4:0]  k_e_q;
  logic        kbig_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ve_q <= 1'b0;
    else if (en) ve_q <= vd_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_e_q <= dist_d_q;
      ks_e_q   <= ks_d_q;
      z_e_q    <= z_d_q;
      t0_e_q   <= t0_d_q;
      ip_e_q   <= 29'(dt_d_q * lo_d_q);
      k_e_q    <= k_d_q;
      kbig_e_q <= kbig_d_q;
    end
  end

  // ---------------- stage F: exp result, z^2 ----------------
  logic [16:0] v_f;
  logic [16:0] e_f;
  assign v_f = t0_e_q - ip_e_q[28:12];
  assign e_f = kbig_e_q ? 17'd0 : (v_f >> k_e_q);

  logic        vf_q;
  logic [16:0] dist_f_q;
  logic [1:0]  ks_f_q;
  logic [29:0] z_f_q;
  logic [16:0] e_f_q;
  logic [59:0] zz_f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vf_q <= 1'b0;
    else if (en) vf_q <= ve_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_f_q <= dist_e_q;
      ks_f_q   <= ks_e_q;
      z_f_q    <= z_e_q;
      e_f_q    <= e_f;
      // z stays below 2^24 for Matern 5/2 (x <= 2^22 times ~2.24)
      zz_f_q   <= 60'(z_e_q[24:0] * z_e_q[24:0]);
    end
  end

  // ---------------- stage G: divide by 3 (reciprocal multiply) ----------------
  // q = floor(n/3) for n < 2^33: (n >> 2) * 0xAAAAAAAB >> 31, then a correction.
  logic [33:0] n3;
  assign n3 = zz_f_q[49:16];

  logic        vg_q;
  logic [16:0] dist_g_q;
  logic [1:0]  ks_g_q;
  logic [29:0] z_g_q;
  logic [16:0] e_g_q;
  logic [33:0] n3_g_q;
  logic [65:0] q3p_g_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vg_q <= 1'b0;
    else if (en) vg_q <= vf_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_g_q <= dist_f_q;
      ks_g_q   <= ks_f_q;
      z_g_q    <= z_f_q;
      e_g_q    <= e_f_q;
      n3_g_q   <= n3;
      // approximate quotient from the top bits, corrected next stage
      q3p_g_q  <= 66'(n3[33:2] * 32'hAAAAAAAB);
    end
  end

  // n>>2 * (2^33/3) / 2^31 approximates floor(n/3) from below, short by at most one
  logic [33:0] q0, r0, q3;
  logic [35:0] p3;
  always_comb begin
    q0 = 34'(q3p_g_q >> 31);
    p3 = 36'(q0) * 36'd3;
    r0 = 34'(36'(n3_g_q) - p3);
    q3 = q0;
    if (r0 >= 34'd6)      q3 = q0 + 34'd2;
    else if (r0 >= 34'd3) q3 = q0 + 34'd1;
  end

  // ---------------- stage H: polynomial ----------------
  logic        vh_q;
  logic [16:0] dist_h_q;
  logic [16:0] e_h_q;
  logic [35:0] poly_h_q;
  logic        plain_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vh_q <= 1'b0;
    else if (en) vh_q <= vg_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_h_q  <= dist_g_q;
      e_h_q     <= e_g_q;
      plain_h_q <= (ks_g_q == 2'(skc_pkg::KERN_EXP)) || (ks_g_q == 2'(skc_pkg::KERN_SQEXP));
      case (ks_g_q)
        2'(skc_pkg::KERN_M32): poly_h_q <= 36'(skc_pkg::Q16_ONE) + 36'(z_g_q);
        2'(skc_pkg::KERN_M52): poly_h_q <= 36'(skc_pkg::Q16_ONE) + 36'(z_g_q) + 36'(q3);
        default:               poly_h_q <= 36'(skc_pkg::Q16_ONE);
      endcase
    end
  end

  // ---------------- stage I: product ----------------
  logic        vi_q;
  logic [16:0] dist_i_q;
  logic [16:0] e_i_q;
  logic        plain_i_q;
  logic [52:0] prod_i_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vi_q <= 1'b0;
    else if (en) vi_q <= vh_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_i_q  <= dist_h_q;
      e_i_q     <= e_h_q;
      plain_i_q <= plain_h_q;
      // poly < 2^36 and e <= 2^16, so the product fits 53 bits
      prod_i_q  <= 53'(poly_h_q * e_h_q);
    end
  end

  logic [36:0] c_raw;
  logic [16:0] corr;
  assign c_raw = plain_i_q ? 37'(e_i_q) : prod_i_q[52:16];
  assign corr  = (c_raw > 37'(skc_pkg::Q16_ONE)) ? skc_pkg::Q16_ONE : c_raw[16:0];

  // ---------------- output register ----------------
  logic [16:0] dist_o_q, corr_o_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= vi_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_o_q <= dist_i_q;
      corr_o_q <= corr;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, corr_o_q, dist_o_q};

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for spatial_kernel_correlation
// Streams random and corner point pairs through the kernel under several
// length scales and kernels, predicts distance and correlation per pair and
// compares every returned transaction in order.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [16:0] distance;
    logic [16:0] correlation;
  } kernel_result_t;

  // Predicts the kernel result for each accepted point pair, checks outputs.
  class corr_scoreboard;
    kernel_result_t    pending_q[$];
    logic [23:0]       inv_ls;
    skc_pkg::kernel_e  ksel;
    int                mismatches;

    function new();
      inv_ls = 24'd65536;
      ksel = skc_pkg::KERN_SQEXP;
      mismatches = 0;
    endfunction

    function longint unsigned exp_neg_q16(longint unsigned z);
      longint unsigned t, k, f, i, lo, v;
      longint unsigned tab [17] = '{65536, 62757, 60097, 57549, 55109, 52773,
        50535, 48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
      t = (z * 94548) >> 16;
      k = t >> 16;
      f = t & 16'hFFFF;
      i = f >> 12;
      lo = f & 12'hFFF;
      if (k >= 17) return 0;
      v = tab[i] - (((tab[i] - tab[i+1]) * lo) >> 12);
      return v >> k;
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void note_pair(logic [127:0] pair);
      longint unsigned sum, ad, dist_v, x, z, e, corr;
      longint d;
      kernel_result_t res;
      sum = 0;
      for (int h = 0; h < 4; h++) begin
        d = longint'($signed(pair[16*h +: 16])) - longint'($signed(pair[16*(h+4) +: 16]));
        ad = (d < 0) ? -d : d;
        if (ad > 131072) ad = 131072;
        sum += ad * ad;
      end
      dist_v = int_sqrt(sum);
      if (dist_v > 131071) dist_v = 131071;
      x = (dist_v * inv_ls) >> 8;
      if (x > (64'd1 << 22)) x = 64'd1 << 22;
      case (ksel)
        skc_pkg::KERN_EXP: corr = exp_neg_q16(x);
        skc_pkg::KERN_M32: begin
          z = (x * 113512) >> 16;
          e = exp_neg_q16(z);
          corr = ((65536 + z) * e) >> 16;
        end
        skc_pkg::KERN_M52: begin
          z = (x * 146543) >> 16;
          e = exp_neg_q16(z);
          corr = ((65536 + z + ((z * z) >> 16) / 3) * e) >> 16;
        end
        default: corr = exp_neg_q16((x * x) >> 17);
      endcase
      if (corr > 65536) corr = 65536;
      res.distance = dist_v[16:0];
      res.correlation = corr[16:0];
      pending_q.push_back(res);
    endfunction

    task check_result(logic [39:0] data);
      kernel_result_t want;
      if (pending_q.size() == 0) begin
        report_error($sformatf("unexpected result %h", data));
        return;
      end
      want = pending_q.pop_front();
      if (data[16:0] !== want.distance)
        report_error($sformatf("distance got %0d want %0d", data[16:0], want.distance));
      if (data[33:17] !== want.correlation)
        report_error($sformatf("correlation got %0d want %0d", data[33:17],
                               want.correlation));
    endtask

    task report_error(string msg);
      mismatches++;
      $display("ERROR @%0t: %s", $time, msg);
    endtask
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;   // a_c0..a_c3, b_c0..b_c3
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [39:0]  m_axis_tdata;        // distance, correlation, zero fill
  logic         cfg_we_i = 1'b0;
  logic [0:0]   cfg_index_i = skc_pkg::REG_INV_LS;
  logic [23:0]  cfg_data_i = '0;

  corr_scoreboard sb = new();
  bit   hold_off = 1'b0;       // long receiver stall request
  int   stall_pct = 30;

  spatial_kernel_correlation DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predict on input acceptance, check on output acceptance.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_pair(s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Receiver: random stalls, with quiet stretches, and forced hold-off.
  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3, 4: return 16'($signed($urandom_range(512)) - 256);  // near points
      default: return 16'($urandom);
    endcase
  endfunction

  // Send one pair; waits for acceptance. Valid stays high across a burst,
  // otherwise it is dropped before the next pair.
  task automatic send_pair(logic [127:0] pair, bit keep);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pair;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (!keep) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_random(int count);
    logic [127:0] p;
    int burst;
    while (count > 0) begin
      burst = $urandom_range(12, 1);
      for (int j = 0; j < burst && count > 0; j++) begin
        for (int h = 0; h < 8; h++) p[16*h +: 16] = pick_coord();
        count--;
        send_pair(p, (j < burst - 1) && (count > 0));
      end
      repeat ($urandom_range(4)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [0:0] idx, logic [23:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == skc_pkg::REG_INV_LS) sb.inv_ls = val;
    else sb.ksel = skc_pkg::kernel_e'(val[1:0]);
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  initial begin
    logic [127:0] p;
    logic [23:0] scales [6] = '{24'd0, 24'd65536, 24'd4096, 24'd300000,
                                24'hFFFFFF, 24'd1};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset config, zero distance, max/min coordinates, opposite corners.
    send_pair('0, 0);
    send_pair({{4{16'h7FFF}}, 64'h0}, 0);
    send_pair({{4{16'h7FFF}}, {4{16'h8000}}}, 0);
    send_pair({{4{16'h8000}}, {4{16'h7FFF}}}, 0);
    send_pair({112'h0, 16'h0100}, 0);
    send_pair({64'h0, 48'h0, 16'hFFFF}, 0);
    for (int k = 0; k < 4; k++) begin
      drain();
      write_reg(skc_pkg::REG_KSEL, 24'(k));
      for (int n = 0; n < 4; n++) begin
        p = '0;
        p[15:0] = 16'(n * 150);  // sweep of small distances
        send_pair(p, 0);
      end
    end

    // Random phases over kernels and scales, one with a long receiver hold-off.
    for (int ph = 0; ph < 12; ph++) begin
      drain();
      write_reg(skc_pkg::REG_KSEL, 24'(ph % 4));
      write_reg(skc_pkg::REG_INV_LS,
                (ph < 6) ? scales[ph] : 24'($urandom_range(24'hFFFFFF)));
      stall_pct = (ph % 3 == 0) ? 0 : 35;
      if (ph == 4) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (200) @(posedge clk_i);
            hold_off = 1'b0;
          end
          send_random(130);
        join
      end else begin
        send_random(118);
      end
    end
    drain();

    if (sb.mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/skc_pkg.sv
hw/rtl/skc_isqrt.sv
hw/rtl/spatial_kernel_correlation.sv
tb/testbench.sv
